FILE: rtl/pstt_pkg.sv
// ----------------------------------------------------------------------------
// Priority sorted task table: shared types and codes
// Request and response transaction layouts, operation modes and status codes.
// ----------------------------------------------------------------------------
package pstt_pkg;

   // Operation modes carried in the request transaction
   localparam logic [2:0] MODE_ADD      = 3'd0;
   localparam logic [2:0] MODE_REMOVE   = 3'd1;
   localparam logic [2:0] MODE_COMPLETE = 3'd2;
   localparam logic [2:0] MODE_LOOKUP   = 3'd3;
   localparam logic [2:0] MODE_DUMP     = 3'd4;

   // Status codes carried in the response transaction
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOTFOUND = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  priority_req;
      logic [15:0] tag;
      logic [7:0]  position;
      logic        undo;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  rank;
      logic [7:0]  entry_priority_out;
      logic [15:0] entry_tag_out;
      logic        completed;
      logic [4:0]  count;
      logic        last;
   } rsp_type;

endpackage

FILE: rtl/priority_sorted_task_table.sv
// ----------------------------------------------------------------------------
// Priority sorted task table
// A table of up to DEPTH entries kept in ascending priority order in a
// single-port-read, single-port-write memory, walked by a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------
//  req_    | in        | req_valid / req_ready | req_type (one operation)
//  rsp_    | out       | rsp_valid / rsp_ready | rsp_type (one or more results)
//
// At most one entry is read per cycle and that single read port sets the pace. An
// add compares entries on the walk up from the tail, moving each larger one back,
// then inserts; a remove reads the entry and moves each entry behind it forward one
// slot; mark complete and look up read the one entry; a rejected request goes
// straight to the output stage; a dump reads and emits each entry in turn. req_ready
// returns once the last result is in the output register, which holds it through
// rsp_ready stalls. Reset clears the state, count and valid flag, not the slots.
// ----------------------------------------------------------------------------
module priority_sorted_task_table
   import pstt_pkg::*;
#(
   parameter int DEPTH         = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int TAG_BITS      = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Widths derived from the table size and entry layout
   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;
   localparam int PW   = PRIORITY_BITS;
   localparam int TW   = TAG_BITS;
   localparam int PEXT = (PW > 8) ? PW : 8;
   localparam int TEXT = (TW > 16) ? TW : 16;
   localparam int EW   = PW + TW + 1;

   // Sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CAP     = 3'd1;
   localparam logic [2:0] S_ADD_CMP = 3'd2;
   localparam logic [2:0] S_ADD_INS = 3'd3;
   localparam logic [2:0] S_RM_SH   = 3'd4;
   localparam logic [2:0] S_EMIT    = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    mode_ff, mode_in;
   logic [PW-1:0] prio_ff, prio_in;
   logic [TW-1:0] tag_ff, tag_in;
   logic          undo_ff, undo_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic          rsp_load;

   // Table memory: each word is {priority, tag, completed}
   logic [EW-1:0] slot_ff [DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   // Field views of the incoming request and of the word just read
   logic [PEXT-1:0] req_prio_ext;
   logic [TEXT-1:0] req_tag_ext;
   logic [PW-1:0]   req_prio;
   logic [TW-1:0]   req_tag;
   logic [AW-1:0]   req_idx;
   logic            pos_ok;
   logic            tbl_empty;
   logic            tbl_full;
   logic [PW-1:0]   e_prio;
   logic [TW-1:0]   e_tag;
   logic            e_done;
   logic [PEXT-1:0] e_prio_ext;
   logic [TEXT-1:0] e_tag_ext;
   logic [PEXT-1:0] new_prio_ext;
   logic [TEXT-1:0] new_tag_ext;

   assign req_prio_ext = PEXT'(req_data.priority_req);
   assign req_tag_ext  = TEXT'(req_data.tag);
   assign req_prio     = req_prio_ext[PW-1:0];
   assign req_tag      = req_tag_ext[TW-1:0];
   assign req_idx      = AW'(req_data.position - 8'd1);
   assign pos_ok       = (req_data.position != 8'd0) &&
                         (CMPW'(req_data.position) <= CMPW'(fill_ff));
   assign tbl_empty    = (fill_ff == '0);
   assign tbl_full     = (fill_ff == CW'(DEPTH));

   assign e_prio       = rd_data_ff[EW-1 -: PW];
   assign e_tag        = rd_data_ff[TW:1];
   assign e_done       = rd_data_ff[0];
   assign e_prio_ext   = PEXT'(e_prio);
   assign e_tag_ext    = TEXT'(e_tag);
   assign new_prio_ext = PEXT'(prio_ff);
   assign new_tag_ext  = TEXT'(tag_ff);

   // Sequencer: at most one memory read and at most one memory write per cycle.
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      prio_in  = prio_ff;
      tag_in   = tag_ff;
      undo_in  = undo_ff;
      idx_in   = idx_ff;
      ptr_in   = ptr_ff;
      fill_in  = fill_ff;
      res_in   = res_ff;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff;
      wr_data  = rd_data_ff;
      rsp_load = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in      = req_data.mode;
               prio_in      = req_prio;
               tag_in       = req_tag;
               undo_in      = req_data.undo;
               idx_in       = req_idx;
               // Default to an entry-less result; overwritten once an entry is found
               res_in       = '0;
               res_in.count = 5'(fill_ff);
               res_in.last  = 1'b1;
               state_in     = S_EMIT;
               unique case (req_data.mode) inside
                  MODE_ADD: begin
                     if (tbl_full) begin
                        res_in.status = STAT_FULL;
                     end else if (tbl_empty) begin
                        ptr_in   = '0;
                        state_in = S_ADD_INS;
                     end else begin
                        // Walk up from the tail, moving larger priorities down
                        rd_en    = 1'b1;
                        rd_addr  = AW'(fill_ff - CW'(1));
                        ptr_in   = AW'(fill_ff - CW'(1));
                        state_in = S_ADD_CMP;
                     end
                  end
                  MODE_DUMP: begin
                     if (tbl_empty) begin
                        res_in.status = STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        ptr_in   = '0;
                        state_in = S_CAP;
                     end
                  end
                  MODE_REMOVE, MODE_COMPLETE, MODE_LOOKUP: begin
                     if (tbl_empty) begin
                        res_in.status = (req_data.mode == MODE_LOOKUP) ?
                                        STAT_NOTFOUND : STAT_EMPTY;
                     end else if (!pos_ok) begin
                        res_in.status = STAT_NOTFOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = req_idx;
                        state_in = S_CAP;
                     end
                  end
                  default: begin
                     res_in.status = STAT_NOTFOUND;
                  end
               endcase
            end
         end

         S_CAP: begin
            res_in.status             = STAT_OK;
            res_in.rank               = 5'(idx_ff) + 5'd1;
            res_in.entry_priority_out = e_prio_ext[7:0];
            res_in.entry_tag_out      = e_tag_ext[15:0];
            res_in.completed          = e_done;
            res_in.count              = 5'(fill_ff);
            res_in.last               = 1'b1;
            state_in                  = S_EMIT;
            case (mode_ff)
               MODE_COMPLETE: begin
                  if (!undo_ff) begin
                     wr_en            = 1'b1;
                     wr_addr          = idx_ff;
                     wr_data          = {e_prio, e_tag, 1'b1};
                     res_in.completed = 1'b1;
                  end
               end
               MODE_REMOVE: begin
                  fill_in      = fill_ff - CW'(1);
                  res_in.count = 5'(fill_ff - CW'(1));
                  if (CW'(idx_ff) < fill_ff - CW'(1)) begin
                     rd_en    = 1'b1;
                     rd_addr  = idx_ff + AW'(1);
                     ptr_in   = idx_ff;
                     state_in = S_RM_SH;
                  end
               end
               MODE_DUMP: begin
                  res_in.rank = 5'(ptr_ff) + 5'd1;
                  res_in.last = ((CW'(ptr_ff) + CW'(1)) == fill_ff);
               end
               default: begin
               end
            endcase
         end

         S_ADD_CMP: begin
            if (e_prio > prio_ff) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff + AW'(1);
               if (ptr_ff == '0) begin
                  state_in = S_ADD_INS;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff - AW'(1);
                  ptr_in  = ptr_ff - AW'(1);
               end
            end else begin
               // Equal priorities stay ahead of the new entry
               ptr_in   = ptr_ff + AW'(1);
               state_in = S_ADD_INS;
            end
         end

         S_ADD_INS: begin
            wr_en                     = 1'b1;
            wr_addr                   = ptr_ff;
            wr_data                   = {prio_ff, tag_ff, 1'b0};
            fill_in                   = fill_ff + CW'(1);
            res_in.status             = STAT_OK;
            res_in.rank               = 5'(ptr_ff) + 5'd1;
            res_in.entry_priority_out = new_prio_ext[7:0];
            res_in.entry_tag_out      = new_tag_ext[15:0];
            res_in.completed          = 1'b0;
            res_in.count              = 5'(fill_ff + CW'(1));
            res_in.last               = 1'b1;
            state_in                  = S_EMIT;
         end

         S_RM_SH: begin
            // Slot ptr takes the entry behind it; fill_ff already holds the new count
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            if ((CW'(ptr_ff) + CW'(1)) < fill_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff + AW'(2);
               ptr_in  = ptr_ff + AW'(1);
            end else begin
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               if ((mode_ff == MODE_DUMP) && !res_ff.last) begin
                  rd_en    = 1'b1;
                  rd_addr  = ptr_ff + AW'(1);
                  ptr_in   = ptr_ff + AW'(1);
                  state_in = S_CAP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
      undo_ff <= undo_in;
      idx_ff  <= idx_in;
      ptr_ff  <= ptr_in;
      res_ff  <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   // Table memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_ff[rd_addr];
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The entry count never runs past the table size.
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("entry count exceeds table size");

   // The count changes only where an entry is inserted or removed.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CAP && state_ff != S_ADD_INS) |=> (fill_ff == $past(fill_ff)))
      else $error("entry count changed outside insert or remove");

   // A full status is only reported against a full table.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STAT_FULL) |-> (rsp_ff.count == 5'(DEPTH)))
      else $error("full status with a table that is not full");

endmodule
